>>> sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Holds the list depth, the field widths, the request and status codes and
// the states of the control sequencer.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 2;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_DUMP_RD,
        S_DUMP_EM,
        S_RESP
    } state_t;

endpackage

>>> sv/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list with insert, delete, update, dump
// Entries live in one synchronous RAM; edits walk the shifted span one entry
// at a time through a read state and a write state.
// ----------------------------------------------------------------------------
// Update and rejected edits go straight to the response; insert shifts the
// entries from the count down to the position, delete those above it down.
// One request is taken at a time; a dump reads each entry through the single
// RAM read port into its read register, then emits it when the output frees.
// Reset clears the count and the control state; RAM contents stay undefined
// and need no clearing pass, since only entries below the count are read.
module positional_list_engine_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ple_pkg::CMD_W-1:0]   cmd,
    input  logic [ple_pkg::POS_W-1:0]   position,
    input  logic [ple_pkg::VAL_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ple_pkg::STAT_W-1:0]  status,
    output logic [ple_pkg::POS_W-1:0]   position_out,
    output logic [ple_pkg::VAL_W-1:0]   value_out,
    output logic                        last
);
    import ple_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    status_t          stat_reg, stat_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]  position_out_reg, position_out_next;
    logic [VAL_W-1:0]  value_out_reg, value_out_next;
    logic              last_reg, last_next;

    logic             accept;
    logic             out_free;
    logic [CMP_W-1:0] pos_in_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] pos_reg_ext;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign pos_in_ext  = CMP_W'(position);
    assign cnt_ext     = CMP_W'(count_reg);
    assign idx_ext     = CMP_W'(idx_reg);
    assign pos_reg_ext = CMP_W'(pos_reg);

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position_out = position_out_reg;
    assign value_out    = value_out_reg;
    assign last         = last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg          <= idx_next;
        pos_reg          <= pos_next;
        val_reg          <= val_next;
        stat_reg         <= stat_next;
        status_reg       <= status_next;
        position_out_reg <= position_out_next;
        value_out_reg    <= value_out_next;
        last_reg         <= last_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        val_next          = val_reg;
        stat_next         = stat_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        position_out_next = position_out_reg;
        value_out_next    = value_out_reg;
        last_next         = last_reg;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg[IDX_W-1:0];
        mem_wdata         = rd_data_reg;
        mem_re            = 1'b0;
        mem_raddr         = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = position;
                    val_next  = value;
                    stat_next = STAT_OK;
                    case (cmd_t'(cmd))
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_RESP;
                            end
                            else if (pos_in_ext > cnt_ext)
                            begin
                                stat_next  = STAT_BADPOS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_UP_RD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_in_ext >= cnt_ext)
                            begin
                                stat_next  = STAT_BADPOS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = CNT_W'(position);
                                state_next = S_DN_RD;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (pos_in_ext >= cnt_ext)
                            begin
                                stat_next = STAT_BADPOS;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = position[IDX_W-1:0];
                                mem_wdata = value;
                            end
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                pos_next   = '0;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                    endcase
                end
            end

            S_UP_RD:
            begin
                if (idx_ext == pos_reg_ext)
                begin
                    // open slot reached: drop the new value in
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[IDX_W-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = S_UP_RD;
            end

            S_DN_RD:
            begin
                if ((idx_reg + CNT_W'(1)) >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(idx_reg + CNT_W'(1));
                    state_next = S_DN_WR;
                end
            end

            S_DN_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[IDX_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_DN_RD;
            end

            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg[IDX_W-1:0];
                state_next = S_DUMP_EM;
            end

            S_DUMP_EM:
            begin
                // hold the read data until the output slot frees up
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = STAT_OK;
                    position_out_next = POS_W'(idx_reg);
                    value_out_next    = rd_data_reg;
                    last_next         = ((idx_reg + CNT_W'(1)) == count_reg);
                    idx_next          = idx_reg + CNT_W'(1);
                    state_next        = ((idx_reg + CNT_W'(1)) == count_reg)
                                        ? S_IDLE : S_DUMP_RD;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = stat_reg;
                    position_out_next = pos_reg;
                    value_out_next    = '0;
                    last_next         = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
